@@ rtl/tcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: the item and
// result beats, opcodes, and the controller-to-datapath command and status.
// ----------------------------------------------------------------------------
package tcw_pkg;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic [5:0] target_row;
        logic [7:0] target_column;
        logic       show_cursor;
    } t_item;

    typedef struct packed {
        logic [5:0]  cursor_row;
        logic [7:0]  cursor_column;
        logic [13:0] cursor_position;
        logic        cursor_update;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attribute;
        logic        scrolled;
    } t_result;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_MOVE  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'd7;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_INIT,
        DP_FILL,
        DP_BLANK,
        DP_PUT,
        DP_MOVE,
        DP_READ,
        DP_PRIME,
        DP_COPY
    } t_dp_op;

    typedef struct packed {
        logic   load;
        logic   finish;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic put_scroll;
        logic sweep_last;
        logic copy_last;
    } t_dp_status;

endpackage
`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the console: reset sweep, item dispatch, scroll and clear
// sweeps, and the result strobe.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [1:0]       i_opcode,
    input  tcw_pkg::t_dp_status   i_status,
    output logic                  o_busy,
    output logic                  o_done,
    output tcw_pkg::t_dp_cmd      o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_MOVE,
        ST_READ,
        ST_FILL,
        ST_PRIME,
        ST_COPY,
        ST_BLANK,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_done;
    logic   open;
    logic   accept;

    assign open   = (r_state == ST_IDLE) || (r_state == ST_FINISH);
    assign accept = open && i_start;
    assign o_busy = !open;
    assign o_done = r_done;

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = accept;
        o_cmd.finish  = (r_state == ST_FINISH);
        o_cmd.op      = DP_NOP;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.op = DP_INIT;
                if (i_status.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE, ST_FINISH: begin
                n_state = ST_IDLE;
                if (accept) begin
                    unique case (i_opcode)
                        OP_PUT:   n_state = ST_PUT;
                        OP_CLEAR: n_state = ST_FILL;
                        OP_MOVE:  n_state = ST_MOVE;
                        OP_READ:  n_state = ST_READ;
                    endcase
                end
            end
            ST_PUT: begin
                o_cmd.op = DP_PUT;
                n_state  = i_status.put_scroll ? ST_PRIME : ST_FINISH;
            end
            ST_MOVE: begin
                o_cmd.op = DP_MOVE;
                n_state  = ST_FINISH;
            end
            ST_READ: begin
                o_cmd.op = DP_READ;
                n_state  = ST_FINISH;
            end
            ST_FILL: begin
                o_cmd.op = DP_FILL;
                if (i_status.sweep_last) n_state = ST_FINISH;
            end
            ST_PRIME: begin
                o_cmd.op = DP_PRIME;
                n_state  = ST_COPY;
            end
            ST_COPY: begin
                o_cmd.op = DP_COPY;
                if (i_status.copy_last) n_state = ST_BLANK;
            end
            ST_BLANK: begin
                o_cmd.op = DP_BLANK;
                if (i_status.sweep_last) n_state = ST_FINISH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_FINISH);
        end
    end

    a_done_follows_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |=> r_done)
        else $error("result strobe missing after finish");

    a_done_only_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_FINISH) |=> !r_done)
        else $error("result strobe without finish");

    a_copy_to_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY && i_status.copy_last) |=> (r_state == ST_BLANK))
        else $error("scroll copy did not hand over to blanking");

endmodule
`default_nettype wire

@@ rtl/tcw_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store, cursor, attribute register, sweep address and result
// register of the console.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [7:0]      i_cfg_wdata,
    input  tcw_pkg::t_item       i_item,
    input  tcw_pkg::t_dp_cmd     i_cmd,
    output tcw_pkg::t_dp_status  o_status,
    output tcw_pkg::t_result     o_result
);
    import tcw_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [RW-1:0] LAST_ROW     = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL     = CW'(COLUMNS - 1);
    localparam logic [AW-1:0] LAST_CELL    = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LAST    = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] COL_STEP     = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_ROW_POS = AW'((ROWS - 1) * COLUMNS);

    logic [15:0]   r_mem [CELLS];
    logic [15:0]   r_rdata;

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_addr, n_addr;
    logic [7:0]    r_attr;

    logic [7:0]    r_char;
    logic [RW-1:0] r_trow;
    logic [CW-1:0] r_tcol;
    logic          r_show;
    logic          r_is_read;
    logic          r_scrolled;
    t_result       r_result;

    logic [RW-1:0] trow_clamped;
    logic [CW-1:0] tcol_clamped;
    logic          nl;
    logic          row_end;
    logic          put_scroll;
    logic [AW-1:0] target_addr;

    logic          w_en;
    logic [AW-1:0] w_addr;
    logic [15:0]   w_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign trow_clamped = (i_item.target_row > 6'(ROWS - 1)) ? LAST_ROW
                                                             : i_item.target_row[RW-1:0];
    assign tcol_clamped = (i_item.target_column > 8'(COLUMNS - 1)) ? LAST_COL
                                                                   : i_item.target_column[CW-1:0];

    assign nl          = (r_char == NEWLINE_CODE);
    assign row_end     = nl || (r_col == LAST_COL);
    assign put_scroll  = (r_row == LAST_ROW) && row_end;
    assign target_addr = AW'(r_trow) * COL_STEP + AW'(r_tcol);

    assign o_status.put_scroll = put_scroll;
    assign o_status.sweep_last = (r_addr == LAST_CELL);
    assign o_status.copy_last  = (r_addr == COPY_LAST);
    assign o_result            = r_result;

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_pos   = r_pos;
        n_addr  = r_addr;
        w_en    = 1'b0;
        w_addr  = r_addr;
        w_data  = {r_attr, SPACE_CODE};
        rd_en   = 1'b0;
        rd_addr = target_addr;
        unique case (i_cmd.op)
            DP_INIT: begin
                w_en   = 1'b1;
                w_data = '0;
                n_addr = r_addr + 1'b1;
            end
            DP_FILL: begin
                w_en   = 1'b1;
                n_addr = r_addr + 1'b1;
                n_row  = '0;
                n_col  = '0;
                n_pos  = '0;
            end
            DP_BLANK: begin
                w_en   = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            DP_PUT: begin
                w_en   = !nl;
                w_addr = r_pos;
                w_data = {r_attr, r_char};
                if (put_scroll) begin
                    n_row = LAST_ROW;
                    n_col = '0;
                    n_pos = LAST_ROW_POS;
                end else if (row_end) begin
                    n_row = r_row + 1'b1;
                    n_col = '0;
                    n_pos = nl ? (r_pos - AW'(r_col) + COL_STEP) : (r_pos + 1'b1);
                end else begin
                    n_col = r_col + 1'b1;
                    n_pos = r_pos + 1'b1;
                end
            end
            DP_MOVE: begin
                n_row = r_trow;
                n_col = r_tcol;
                n_pos = target_addr;
            end
            DP_READ: begin
                rd_en = 1'b1;
            end
            DP_PRIME: begin
                rd_en   = 1'b1;
                rd_addr = COL_STEP;
            end
            DP_COPY: begin
                w_en    = 1'b1;
                w_data  = r_rdata;
                rd_en   = (r_addr != COPY_LAST);
                rd_addr = r_addr + COL_STEP + 1'b1;
                n_addr  = r_addr + 1'b1;
            end
            default: begin
                n_addr = r_addr;
            end
        endcase
        if (i_cmd.load) begin
            n_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_pos  <= '0;
            r_addr <= '0;
            r_attr <= ATTR_RESET;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_pos  <= n_pos;
            r_addr <= n_addr;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char     <= i_item.char_code;
            r_trow     <= trow_clamped;
            r_tcol     <= tcol_clamped;
            r_show     <= i_item.show_cursor;
            r_is_read  <= (i_item.opcode == OP_READ);
            r_scrolled <= 1'b0;
        end else if (i_cmd.op == DP_PUT && put_scroll) begin
            r_scrolled <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_result.cursor_row      <= 6'(r_row);
            r_result.cursor_column   <= 8'(r_col);
            r_result.cursor_position <= 14'(r_pos);
            r_result.cursor_update   <= r_show;
            r_result.cell_char       <= r_is_read ? r_rdata[7:0] : '0;
            r_result.cell_attribute  <= r_is_read ? r_rdata[15:8] : '0;
            r_result.scrolled        <= r_scrolled;
        end
    end

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= LAST_ROW) && (r_col <= LAST_COL))
        else $error("cursor left the screen");

    a_pos_matches_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos == AW'(r_row) * COL_STEP + AW'(r_col))
        else $error("linear cursor position out of step with row and column");

endmodule
`default_nettype wire

@@ rtl/text_console_writer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console: screen store of character and attribute cells with a
// cursor, driven by put, clear, move and read commands.
//
// Command channel: an item beat is taken at a rising edge with start high
// and busy low. Each item gives one result beat on o_result, marked by
// o_done for exactly one cycle; the receiver cannot stall it.
// Configuration: i_cfg_we writes i_cfg_wdata into the attribute register.
//
// Command sequencing, with CELLS = ROWS * COLUMNS:
//   put, move, read    command step, then finish step and result; the
//                      next command can be taken in the finish step
//   put with scroll    rows copied up with one read and one write of the
//                      screen store per cycle, then the last row blanked
//   clear              all CELLS cells, one cell a cycle, then the result
// After reset the block holds busy high while it zeroes all CELLS cells
// of the screen store, one cell a cycle; the cursor starts at row 0,
// column 0 and the attribute register at 7.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  tcw_pkg::t_item     i_item,
    output logic               o_done,
    output tcw_pkg::t_result   o_result,
    input  wire logic          i_cfg_we,
    input  wire logic [7:0]    i_cfg_wdata
);
    import tcw_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .i_status (status),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_cmd    (cmd)
    );

    tcw_datapath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire
